@@ rtl/core/pcx_rle_line_encoder_core_defines.svh @@
// assertion macros for the pcx run-length line encoder
// used by the rtl files that carry concurrent checks; expects clk_i and rst_ni in scope
`ifndef PCX_RLE_LINE_ENCODER_CORE_DEFINES_SVH
`define PCX_RLE_LINE_ENCODER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define PCX_ASSERT(lbl, prop) lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
  (prop)) else $error("pcx encoder check failed");
`define PCX_ASSERT_IMP(lbl, ante, cons) `PCX_ASSERT(lbl, (ante) |-> (cons))
`else
`define PCX_ASSERT(lbl, prop)
`define PCX_ASSERT_IMP(lbl, ante, cons)
`endif

`endif

@@ rtl/core/pcx_pkg.sv @@
// shared types, constants and helpers of the pcx run-length line encoder
// no dependencies
package pcx_pkg;

  localparam int unsigned ColumnBits = 16;
  localparam int unsigned WidthBits  = 16;
  localparam int unsigned LenBits    = 6;
  localparam int unsigned QDepth     = 4;
  localparam int unsigned QPtrBits   = $clog2(QDepth);
  localparam int unsigned QCntBits   = $clog2(QDepth + 1);

  localparam logic [WidthBits-1:0] LineWidthReset = 16'd320;
  localparam logic [LenBits-1:0]   MaxRun         = 6'd63;
  localparam logic [7:0]           RawLimit       = 8'd64;
  localparam logic [7:0]           CountMark      = 8'hC0;

  // one closed run
  typedef struct packed {
    logic [7:0]         value;
    logic [LenBits-1:0] len;
  } run_t;

  // runs closed by one pixel: first by a value change or split, then by line end
  typedef struct packed {
    logic a_vld;
    run_t a;
    logic b_vld;
    run_t b;
  } cmd_t;

  // queue status seen by producer and consumer
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_A_HEAD,
    PH_A_VAL,
    PH_B_HEAD,
    PH_B_VAL
  } phase_e;

  // a single short dark pixel goes out as one raw byte
  function automatic logic is_raw(run_t r);
    return (r.len == LenBits'(1)) && (r.value < RawLimit);
  endfunction

  // first byte of a run: raw value or count byte
  function automatic logic [7:0] head_byte(run_t r);
    return is_raw(r) ? r.value : (CountMark | {2'b00, r.len});
  endfunction

endpackage

@@ rtl/core/pcx_front.sv @@
// front end: accepts pixels, tracks the open run and column, closes runs
// depends on pcx_pkg
module pcx_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [pcx_pkg::WidthBits-1:0]    cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [7:0]                       pixel_i,
  input  pcx_pkg::q_stat_t                 q_stat_i,
  output logic                             push_o,
  output pcx_pkg::cmd_t                    push_cmd_o
);

  logic [pcx_pkg::WidthBits-1:0]  line_width_q;
  logic [7:0]                     run_val_q, run_val_d;
  logic [pcx_pkg::LenBits-1:0]    run_len_q, run_len_d;
  logic [pcx_pkg::ColumnBits-1:0] column_q, column_d;
  logic [pcx_pkg::ColumnBits-1:0] col_next;
  logic                           accept, extend, line_end;
  logic [7:0]                     new_val;
  logic [pcx_pkg::LenBits-1:0]    new_len;
  pcx_pkg::cmd_t                  cmd;

  assign accept     = in_valid_i && !q_stat_i.full;
  assign in_stall_o = q_stat_i.full;

  // run bookkeeping for the pixel at the input
  always_comb begin
    extend   = (run_len_q != '0) && (pixel_i == run_val_q) && (run_len_q < pcx_pkg::MaxRun);
    new_val  = extend ? run_val_q : pixel_i;
    new_len  = extend ? (run_len_q + pcx_pkg::LenBits'(1)) : pcx_pkg::LenBits'(1);
    col_next = column_q + pcx_pkg::ColumnBits'(1);
    line_end = (col_next == line_width_q[pcx_pkg::ColumnBits-1:0]);

    cmd.a_vld   = !extend && (run_len_q != '0);
    cmd.a.value = run_val_q;
    cmd.a.len   = run_len_q;
    cmd.b_vld   = line_end;
    cmd.b.value = new_val;
    cmd.b.len   = new_len;

    run_val_d = run_val_q;
    run_len_d = run_len_q;
    column_d  = column_q;
    if (accept) begin
      run_val_d = new_val;
      run_len_d = line_end ? '0 : new_len;
      column_d  = line_end ? '0 : col_next;
    end
  end

  assign push_o     = accept && (cmd.a_vld || cmd.b_vld);
  assign push_cmd_o = cmd;

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= pcx_pkg::LineWidthReset;
      run_val_q    <= '0;
      run_len_q    <= '0;
      column_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        line_width_q <= cfg_wdata_i;
      end
      run_val_q <= run_val_d;
      run_len_q <= run_len_d;
      column_q  <= column_d;
    end
  end

endmodule

@@ rtl/core/pcx_cmdq.sv @@
// short command queue between front end and byte emitter
// depends on pcx_pkg and the assertion macro header
`include "pcx_rle_line_encoder_core_defines.svh"
module pcx_cmdq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  pcx_pkg::cmd_t    push_cmd_i,
  input  logic             pop_i,
  output pcx_pkg::cmd_t    head_o,
  output pcx_pkg::q_stat_t stat_o
);

  pcx_pkg::cmd_t                mem_q [pcx_pkg::QDepth];
  logic [pcx_pkg::QPtrBits-1:0] wr_ptr_q, rd_ptr_q;
  logic [pcx_pkg::QCntBits-1:0] cnt_q;

  assign stat_o.full  = (cnt_q == pcx_pkg::QCntBits'(pcx_pkg::QDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign head_o       = mem_q[rd_ptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + pcx_pkg::QPtrBits'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + pcx_pkg::QPtrBits'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + pcx_pkg::QCntBits'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - pcx_pkg::QCntBits'(1);
      end
    end
  end

  `PCX_ASSERT_IMP(a_no_push_full, push_i, !stat_o.full)
  `PCX_ASSERT_IMP(a_no_pop_empty, pop_i, !stat_o.empty)
  `PCX_ASSERT(a_cnt_range, cnt_q <= pcx_pkg::QCntBits'(pcx_pkg::QDepth))
  `PCX_ASSERT_IMP(a_push_nonempty, push_i, push_cmd_i.a_vld || push_cmd_i.b_vld)

endmodule

@@ rtl/core/pcx_back.sv @@
// back end: turns closed runs into raw, count and value bytes, one per cycle while the output is not stalled
// depends on pcx_pkg and the assertion macro header
`include "pcx_rle_line_encoder_core_defines.svh"
module pcx_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pcx_pkg::q_stat_t q_stat_i,
  input  pcx_pkg::cmd_t    q_head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       out_byte_o
);

  pcx_pkg::phase_e phase_q, phase_d, phase_after;
  pcx_pkg::cmd_t   rec_q, rec_d;
  logic            out_vld_q, out_vld_d;
  logic [7:0]      out_byte_q, out_byte_d;
  logic [7:0]      cur_byte;
  logic            load_ok, emit, done;

  assign load_ok = !out_vld_q || !out_stall_i;
  assign emit    = (phase_q != pcx_pkg::PH_IDLE) && load_ok;

  // phase following the current one, skipping absent or raw parts
  always_comb begin
    unique case (phase_q)
      pcx_pkg::PH_A_HEAD: begin
        if (!pcx_pkg::is_raw(rec_q.a)) phase_after = pcx_pkg::PH_A_VAL;
        else if (rec_q.b_vld)          phase_after = pcx_pkg::PH_B_HEAD;
        else                           phase_after = pcx_pkg::PH_IDLE;
      end
      pcx_pkg::PH_A_VAL: begin
        phase_after = rec_q.b_vld ? pcx_pkg::PH_B_HEAD : pcx_pkg::PH_IDLE;
      end
      pcx_pkg::PH_B_HEAD: begin
        phase_after = pcx_pkg::is_raw(rec_q.b) ? pcx_pkg::PH_IDLE : pcx_pkg::PH_B_VAL;
      end
      default: begin
        phase_after = pcx_pkg::PH_IDLE;
      end
    endcase
  end

  // next state: advance on emit, load the next record when finished
  always_comb begin
    done    = (phase_q == pcx_pkg::PH_IDLE) || (emit && (phase_after == pcx_pkg::PH_IDLE));
    pop_o   = done && !q_stat_i.empty;
    phase_d = phase_q;
    rec_d   = rec_q;
    if (emit) begin
      phase_d = phase_after;
    end
    if (pop_o) begin
      rec_d   = q_head_i;
      phase_d = q_head_i.a_vld ? pcx_pkg::PH_A_HEAD : pcx_pkg::PH_B_HEAD;
    end
  end

  // byte for the current phase and output register load
  always_comb begin
    unique case (phase_q)
      pcx_pkg::PH_A_HEAD: cur_byte = pcx_pkg::head_byte(rec_q.a);
      pcx_pkg::PH_A_VAL:  cur_byte = rec_q.a.value;
      pcx_pkg::PH_B_HEAD: cur_byte = pcx_pkg::head_byte(rec_q.b);
      pcx_pkg::PH_B_VAL:  cur_byte = rec_q.b.value;
      default:            cur_byte = '0;
    endcase
    out_vld_d  = load_ok ? emit : out_vld_q;
    out_byte_d = emit ? cur_byte : out_byte_q;
  end

  assign out_valid_o = out_vld_q;
  assign out_byte_o  = out_byte_q;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= pcx_pkg::PH_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rec_q      <= rec_d;
    out_byte_q <= out_byte_d;
  end

  `PCX_ASSERT_IMP(a_a_phase_valid,
                  (phase_q == pcx_pkg::PH_A_HEAD) || (phase_q == pcx_pkg::PH_A_VAL),
                  rec_q.a_vld)
  `PCX_ASSERT_IMP(a_b_phase_valid,
                  (phase_q == pcx_pkg::PH_B_HEAD) || (phase_q == pcx_pkg::PH_B_VAL),
                  rec_q.b_vld)
  `PCX_ASSERT_IMP(a_val_not_raw, phase_q == pcx_pkg::PH_A_VAL, !pcx_pkg::is_raw(rec_q.a))
  `PCX_ASSERT_IMP(a_pop_when_free, pop_o,
                  (phase_q == pcx_pkg::PH_IDLE) || (phase_after == pcx_pkg::PH_IDLE))

endmodule

@@ rtl/core/pcx_rle_line_encoder_core.sv @@
// top level of the pcx run-length line encoder
// depends on pcx_pkg, pcx_front, pcx_cmdq and pcx_back
//
//   channel   direction  handshake                     payload
//   pixel     in         in_valid_i / in_stall_o       pixel_i[7:0]
//   byte      out        out_valid_o / out_stall_i     out_byte_o[7:0]
//   config    in         cfg_we_i                      cfg_wdata_i[15:0] (line width)
//
// a pixel can be taken every cycle while the four-entry run queue has room;
// the emitter sends one byte per cycle while the output is not stalled, so a pixel
// giving two bytes occupies it for both; worst case is two runs closed, four bytes.
// closed runs pass the queue, then the record and phase registers, then out_byte_q.
// reset clears run state, column, queue and output valid; line width resets to 320.
// a stalled output holds its byte; the front keeps taking pixels until the queue fills.
module pcx_rle_line_encoder_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pcx_pkg::WidthBits-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    pixel_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    out_byte_o
);

  pcx_pkg::q_stat_t q_stat;
  pcx_pkg::cmd_t    push_cmd, q_head;
  logic             push, pop;

  // pixel intake and run tracking
  pcx_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .pixel_i    (pixel_i),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .push_cmd_o (push_cmd)
  );

  // closed-run queue
  pcx_cmdq u_cmdq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_cmd_i(push_cmd),
    .pop_i     (pop),
    .head_o    (q_head),
    .stat_o    (q_stat)
  );

  // byte emitter
  pcx_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_stat_i   (q_stat),
    .q_head_i   (q_head),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_byte_o (out_byte_o)
  );

endmodule

@@ sim/tb_pcx_rle_line_encoder_core.sv @@
// testbench for pcx_rle_line_encoder_core: pixel and byte channels under random gaps and stalls
// encoded bytes are predicted in-bench and compared in order; depends on pcx_pkg and the rtl
`timescale 1ns / 1ps

module tb_pcx_rle_line_encoder_core;

  localparam int CycleLimit  = 2_000_000;
  localparam int DrainCycles = 16;
  localparam int PhaseItems  = 50;
  localparam int IdleMax     = 17;

  // block ports
  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          cfg_we_i    = 1'b0;
  logic [pcx_pkg::WidthBits-1:0] cfg_wdata_i = '0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_stall_o;
  logic [7:0]                    pixel_i     = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic [7:0]                    out_byte_o;

  // stimulus and expected stream
  logic [7:0] pixel_feed[$];
  logic [7:0] pending_bytes[$];

  // predicted encoder state
  logic [pcx_pkg::WidthBits-1:0]  width_m = pcx_pkg::LineWidthReset;
  logic [7:0]                     run_val = '0;
  logic [pcx_pkg::LenBits-1:0]    run_len = '0;
  logic [pcx_pkg::ColumnBits-1:0] col_m   = '0;

  // transfer flags sampled at the rising edge
  bit pixel_xfer = 1'b0;
  bit byte_xfer  = 1'b0;

  int gap_max    = IdleMax;
  int stall_max  = IdleMax;
  int gap_left   = 0;
  int hold_left  = 0;
  int cycle_count = 0;
  int errors     = 0;
  int pixels_in  = 0;
  int bytes_out  = 0;
  logic [7:0] want;

  // short directed sequences
  logic [7:0] opening_px [16] = '{8'd0, 8'd63, 8'd64, 8'd255, 8'd5, 8'd5, 8'd170, 8'd85,
                                  8'd200, 8'd200, 8'd200, 8'd1, 8'd63, 8'd63, 8'd128, 8'd7};
  logic [7:0] narrow_px  [10] = '{8'd9, 8'd9, 8'd200, 8'd200, 8'd0, 8'd63, 8'd64, 8'd255,
                                  8'd42, 8'd42};
  logic [7:0] wide_px    [5]  = '{8'd12, 8'd12, 8'd100, 8'd100, 8'd100};

  pcx_rle_line_encoder_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .pixel_i     (pixel_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o)
  );

  always #1 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    $display("error at cycle %0d: %s", cycle_count, msg);
    errors++;
  endtask

  // close the open run into raw or count/value bytes
  task automatic flush_run();
    if (run_len != '0) begin
      if (run_len == 6'd1 && run_val < pcx_pkg::RawLimit) begin
        pending_bytes.push_back(run_val);
      end else begin
        pending_bytes.push_back(pcx_pkg::CountMark | {2'b00, run_len});
        pending_bytes.push_back(run_val);
      end
      run_len = '0;
    end
  endtask

  // advance the run and column by one accepted pixel
  task automatic encode_pixel(input logic [7:0] p);
    if (run_len != '0 && p == run_val && run_len < pcx_pkg::MaxRun) begin
      run_len = run_len + pcx_pkg::LenBits'(1);
    end else begin
      flush_run();
      run_val = p;
      run_len = 6'd1;
    end
    col_m = col_m + pcx_pkg::ColumnBits'(1);
    if (col_m == width_m[pcx_pkg::ColumnBits-1:0]) begin
      flush_run();
      col_m = '0;
    end
  endtask

  // monitor: config writes, pixel transfers and byte checks
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_xfer = 1'b0;
      byte_xfer  = 1'b0;
    end else begin
      cycle_count++;
      if (cfg_we_i) width_m = cfg_wdata_i;
      pixel_xfer = in_valid_i && !in_stall_o;
      byte_xfer  = out_valid_o && !out_stall_i;
      if (byte_xfer) begin
        if (pending_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h", out_byte_o));
        end else begin
          want = pending_bytes.pop_front();
          bytes_out++;
          if (out_byte_o !== want)
            report_mismatch($sformatf("byte %02h, expected %02h", out_byte_o, want));
        end
      end
      if (pixel_xfer) begin
        pixels_in++;
        encode_pixel(pixel_i);
      end
    end
  end

  // pixel driver: random gap after each item, payload held while stalled
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left = 0;
    end else if (!in_valid_i || pixel_xfer) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pixel_feed.size() > 0) begin
        in_valid_i <= 1'b1;
        pixel_i    <= pixel_feed.pop_front();
        gap_left = $urandom_range(0, gap_max);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // byte receiver: random stall after each transfer
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left = 0;
    end else begin
      if (byte_xfer) hold_left = $urandom_range(0, stall_max);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // watchdog
  initial begin
    wait (cycle_count >= CycleLimit);
    $display("timeout after %0d cycles", cycle_count);
    $display("pcx_rle_line_encoder_core: mismatch");
    $finish;
  end

  // wait until every queued pixel is taken and every byte has come out
  task automatic settle();
    while (pixel_feed.size() != 0 || in_valid_i || pending_bytes.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_line_width(input logic [pcx_pkg::WidthBits-1:0] w);
    settle();
    @(negedge clk_i);
    cfg_wdata_i <= w;
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // pixels still needed to reach the end of the line under width w
  function automatic int pixels_to_line_end(input int w);
    if (w > int'(col_m)) return w - int'(col_m);
    return 65536 - int'(col_m) + w;
  endfunction

  // runs of random value and length, biased toward short runs and splits unless long runs are asked for
  task automatic push_runs(input int count, input bit long_runs);
    int n;
    int len;
    int pick;
    logic [7:0] v;
    n = 0;
    while (n < count) begin
      pick = $urandom_range(0, 99);
      if (long_runs)      len = $urandom_range(1, 140);
      else if (pick < 70) len = $urandom_range(1, 3);
      else if (pick < 92) len = $urandom_range(4, 40);
      else                len = $urandom_range(63, 66);
      if ($urandom_range(0, 1)) v = 8'($urandom_range(0, 63));
      else                      v = 8'($urandom_range(0, 255));
      if (len > count - n) len = count - n;
      repeat (len) pixel_feed.push_back(v);
      n += len;
    end
  endtask

  initial begin
    int w;
    int pick;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset width of 320: raw, count, bit patterns
    foreach (opening_px[i]) pixel_feed.push_back(opening_px[i]);

    // width zero: no line end within reach, long runs split at 63
    set_line_width(16'd0);
    gap_max   = 0;
    stall_max = 0;
    push_runs(70, 1'b1);

    // width below the current column: passing it does not end the line
    set_line_width(16'd10);
    push_runs(20, 1'b1);

    // close the line a few pixels past the column
    settle();
    w = int'(col_m) + 4;
    set_line_width(w[pcx_pkg::WidthBits-1:0]);
    push_runs(pixels_to_line_end(w), 1'b0);

    // one-pixel lines: equal neighbors never merge
    set_line_width(16'd1);
    gap_max   = IdleMax;
    stall_max = IdleMax;
    foreach (narrow_px[i]) pixel_feed.push_back(narrow_px[i]);

    // widest line, then a narrower width with the run left open
    set_line_width(16'd65535);
    foreach (wide_px[i]) pixel_feed.push_back(wide_px[i]);
    set_line_width(16'd40);
    repeat (3) pixel_feed.push_back(8'd100);
    push_runs(pixels_to_line_end(40) - 3, 1'b0);

    // random phases over a mix of widths
    repeat (6) begin
      pick = $urandom_range(0, 5);
      case (pick)
        0: w = 1;
        1: w = $urandom_range(2, 12);
        2: w = 63;
        3: w = 64;
        4: w = $urandom_range(13, 200);
        default: w = 65535;
      endcase
      settle();
      if (w <= int'(col_m)) w = int'(col_m) + 1 + $urandom_range(0, 60);
      set_line_width(w[pcx_pkg::WidthBits-1:0]);
      push_runs(PhaseItems, 1'b0);
    end

    settle();
    if (pending_bytes.size() != 0)
      report_mismatch($sformatf("%0d bytes never arrived", pending_bytes.size()));
    $display("%0d pixels encoded, %0d bytes checked in %0d cycles", pixels_in, bytes_out,
             cycle_count);
    $display("line widths 320, 0, 10, a short closing width, 1, 65535, 40 and six random ones");
    if (errors == 0) begin
      $display("pcx_rle_line_encoder_core: match");
    end else begin
      $display("pcx_rle_line_encoder_core: mismatch");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/pcx_pkg.sv
rtl/core/pcx_front.sv
rtl/core/pcx_cmdq.sv
rtl/core/pcx_back.sv
rtl/core/pcx_rle_line_encoder_core.sv
sim/tb_pcx_rle_line_encoder_core.sv
